[rtl/dcfcc_pkg.sv]
// ----------------------------------------------------------------------------
// dcfcc_pkg - shared types, constants and CRC helpers for the frame codec
// Register map codes, payload structs and the CRC8 basis math.
// ----------------------------------------------------------------------------
package dcfcc_pkg;

   // Command codes
   localparam logic CMD_BUILD_WRITE = 1'b0;
   localparam logic CMD_CHECK_REPLY = 1'b1;

   // Register indexes (byte address = 4 * index)
   localparam int          CSR_ADDR_WIDTH  = 4;
   localparam int          CSR_INDEX_WIDTH = 2;
   localparam logic [1:0]  REG_CRC_POLYNOMIAL      = 2'd0;
   localparam logic [1:0]  REG_WRITE_TAIL_PATTERN  = 2'd1;
   localparam logic [1:0]  REG_CONTROL_LOW_ADDRESS = 2'd2;

   // Reset values
   localparam logic [7:0]  CRC_POLY_RESET     = 8'h2F;
   localparam logic [2:0]  TAIL_RESET         = 3'd2;
   localparam logic [5:0]  CONTROL_LOW_RESET  = 6'd14;

   // Field masks
   localparam logic [7:0]  BYTE_MASK    = 8'hFF;
   localparam logic [11:0] CODE_MASK    = 12'hFFF;
   localparam logic [5:0]  REG_MASK     = 6'h3F;

   // Millivolt conversion: code * 4000 / 4095 + 1000.
   // 4000/4095 reduces to 800/819; a 32-bit scaled reciprocal of 819 times 800
   // gives the exact floor for every 12-bit code.
   localparam int VOLT_SCALE  = 4000;
   localparam int VOLT_DIV    = 4095;
   localparam int VOLT_OFFSET = 1000;
   localparam int VOLT_GCD    = 5;
   localparam int VOLT_NUM    = VOLT_SCALE / VOLT_GCD;
   localparam int VOLT_DEN    = VOLT_DIV / VOLT_GCD;
   localparam int VOLT_SHIFT  = 32;
   localparam logic [63:0] VOLT_RECIP_WIDE =
      64'(VOLT_NUM) * (((64'd1 << VOLT_SHIFT) + 64'(VOLT_DEN) - 64'd1) / 64'(VOLT_DEN));
   localparam logic [31:0] VOLT_RECIP = VOLT_RECIP_WIDE[31:0];
   localparam int VOLT_PROD_WIDTH = 12 + 32;

   // Basis of the CRC byte step: entry i is the step applied to a byte with only bit i set
   typedef logic [7:0][7:0] crc_basis_type;

   typedef struct packed {
      logic        command;
      logic [4:0]  device_index;
      logic [5:0]  reg_address;
      logic        broadcast;
      logic [7:0]  write_data;
      logic [31:0] reply_word;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] frame_word;
      logic        crc_ok;
      logic        match_ok;
      logic [4:0]  reply_device;
      logic [5:0]  reply_register;
      logic [7:0]  reply_data;
      logic [11:0] adc_code;
      logic [12:0] voltage_mv;
   } rsp_payload_type;

   function automatic logic [4:0] reverse5(input logic [4:0] a);
      return {a[0], a[1], a[2], a[3], a[4]};
   endfunction

   // x^(8+i) mod p for i = 0..7
   function automatic crc_basis_type crc_basis(input logic [7:0] poly);
      crc_basis_type b;
      b[0] = poly;
      for (int i = 1; i < 8; i++) begin
         b[i] = {b[i-1][6:0], 1'b0} ^ (b[i-1][7] ? poly : 8'h00);
      end
      return b;
   endfunction

   // Byte step is linear over GF(2): XOR of the basis rows picked by the byte
   function automatic logic [7:0] crc_step(input logic [7:0] v, input crc_basis_type b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         acc = acc ^ (v[i] ? b[i] : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] crc24(input logic [23:0] v, input crc_basis_type b);
      logic [7:0] c;
      c = crc_step(v[23:16], b);
      c = crc_step(c ^ v[15:8], b);
      return c ^ v[7:0];
   endfunction

endpackage

[rtl/dcfcc_channels.sv]
// ----------------------------------------------------------------------------
// dcfcc channels - valid/ready interfaces for request and response transfers
// A transfer completes on a rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface dcfcc_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [4:0]  device_index;
   logic [5:0]  reg_address;
   logic        broadcast;
   logic [7:0]  write_data;
   logic [31:0] reply_word;

   modport source (output valid, output command, output device_index, output reg_address,
                   output broadcast, output write_data, output reply_word, input ready);
   modport sink   (input valid, input command, input device_index, input reg_address,
                   input broadcast, input write_data, input reply_word, output ready);
endinterface

interface dcfcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] frame_word;
   logic        crc_ok;
   logic        match_ok;
   logic [4:0]  reply_device;
   logic [5:0]  reply_register;
   logic [7:0]  reply_data;
   logic [11:0] adc_code;
   logic [12:0] voltage_mv;

   modport source (output valid, output frame_word, output crc_ok, output match_ok,
                   output reply_device, output reply_register, output reply_data,
                   output adc_code, output voltage_mv, input ready);
   modport sink   (input valid, input frame_word, input crc_ok, input match_ok,
                   input reply_device, input reply_register, input reply_data,
                   input adc_code, input voltage_mv, output ready);
endinterface

[rtl/daisy_chain_frame_crc_codec_core.sv]
// ----------------------------------------------------------------------------
// daisy_chain_frame_crc_codec_core - CRC8 daisy-chain SPI frame build/check
// Builds 32-bit write frames and checks 32-bit reply frames, one per transfer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  -------   ---------  -----------------  -----------------------------------------
//  req_if    in         valid/ready        command, device, register, data, reply
//  rsp_if    out        valid/ready        frame, crc/match flags, reply fields, mV
//  csr_*     in/out     APB, pready=1      polynomial, tail pattern, control-low addr
//
//  - One transfer per cycle while rsp_if takes results; each request passes the
//    input register, then result register, with the single CRC/convert pass between.
//  - reset (sync, active high) empties both stages and restores register defaults.
//  - A stalled result holds in the result register; the input register still
//    takes a transfer while empty or while the result register has room or drains.
//  - CSR reads have no wait states.
//
module daisy_chain_frame_crc_codec_core (
   input  logic                                   clock,
   input  logic                                   reset,
   dcfcc_req_if.sink                              req_if,
   dcfcc_rsp_if.source                            rsp_if,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [dcfcc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [7:0]                  poly_ff, poly_in;
   logic [2:0]                  tail_ff, tail_in;
   logic [5:0]                  ctl_low_ff, ctl_low_in;
   // CRC basis is rebuilt from the written data on the same edge as the polynomial,
   // so the datapath never sees the serial basis chain.
   dcfcc_pkg::crc_basis_type    basis_ff, basis_in;

   logic                                   csr_write;
   logic [dcfcc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[dcfcc_pkg::CSR_ADDR_WIDTH-1:2];

   always_comb begin
      poly_in    = poly_ff;
      tail_in    = tail_ff;
      ctl_low_in = ctl_low_ff;
      basis_in   = basis_ff;
      if (csr_write) begin
         unique case (csr_index)
            dcfcc_pkg::REG_CRC_POLYNOMIAL: begin
               poly_in  = csr_pwdata[7:0];
               basis_in = dcfcc_pkg::crc_basis(csr_pwdata[7:0]);
            end
            dcfcc_pkg::REG_WRITE_TAIL_PATTERN: begin
               tail_in = csr_pwdata[2:0];
            end
            dcfcc_pkg::REG_CONTROL_LOW_ADDRESS: begin
               ctl_low_in = csr_pwdata[5:0];
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         dcfcc_pkg::REG_CRC_POLYNOMIAL:      csr_prdata = {24'd0, poly_ff};
         dcfcc_pkg::REG_WRITE_TAIL_PATTERN:  csr_prdata = {29'd0, tail_ff};
         dcfcc_pkg::REG_CONTROL_LOW_ADDRESS: csr_prdata = {26'd0, ctl_low_ff};
         default:                            csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Two-stage pipeline control: input register (s1), result register (s2)
   // ------------------------------------------------------------------
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s2_valid_ff, s2_valid_in;
   dcfcc_pkg::req_payload_type   s1_ff, s1_in;
   dcfcc_pkg::rsp_payload_type   s2_ff, s2_in;
   dcfcc_pkg::rsp_payload_type   result;

   logic s2_open;   // result register free or draining this cycle
   logic s1_move;   // s1 content moves to s2
   logic req_take;  // request transfer this cycle

   assign s2_open      = !s2_valid_ff || rsp_if.ready;
   assign s1_move      = s1_valid_ff && s2_open;
   assign req_if.ready = !s1_valid_ff || s2_open;
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_take) begin
         s1_valid_in        = 1'b1;
         s1_in.command      = req_if.command;
         s1_in.device_index = req_if.device_index;
         s1_in.reg_address  = req_if.reg_address;
         s1_in.broadcast    = req_if.broadcast;
         s1_in.write_data   = req_if.write_data;
         s1_in.reply_word   = req_if.reply_word;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   assign s2_valid_in = s2_open ? s1_valid_ff : s2_valid_ff;
   assign s2_in       = s1_move ? result : s2_ff;

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   // Write frame: bits 31:11 = {rev(dev), reg, data, bcast, 0}; bit 17 is data bit 4
   logic [7:0]   wr_data;
   logic [20:0]  wr_head;
   logic [7:0]   wr_crc;
   logic [31:0]  wr_frame;

   assign wr_data  = s1_ff.write_data |
                     ((s1_ff.reg_address == ctl_low_ff) ? 8'h10 : 8'h00);
   assign wr_head  = {dcfcc_pkg::reverse5(s1_ff.device_index), s1_ff.reg_address,
                      wr_data, s1_ff.broadcast, 1'b0};
   assign wr_crc   = dcfcc_pkg::crc24({3'd0, wr_head}, basis_ff);
   assign wr_frame = {wr_head, wr_crc, tail_ff};

   // Reply check: CRC over bits 31:10 against bits 9:2
   logic [7:0]   rd_crc;
   logic [4:0]   rd_dev;
   logic [5:0]   rd_reg;
   logic [11:0]  rd_code;
   logic [dcfcc_pkg::VOLT_PROD_WIDTH-1:0] rd_prod;
   logic [11:0]  rd_quot;

   assign rd_crc  = dcfcc_pkg::crc24({2'd0, s1_ff.reply_word[31:10]}, basis_ff);
   assign rd_dev  = dcfcc_pkg::reverse5(s1_ff.reply_word[31:27]);
   assign rd_reg  = s1_ff.reply_word[26:21] & dcfcc_pkg::REG_MASK;
   assign rd_code = s1_ff.reply_word[22:11] & dcfcc_pkg::CODE_MASK;
   // floor(code * 4000 / 4095) by scaled reciprocal, exact over all 12-bit codes
   assign rd_prod = dcfcc_pkg::VOLT_PROD_WIDTH'(rd_code) *
                    dcfcc_pkg::VOLT_PROD_WIDTH'(dcfcc_pkg::VOLT_RECIP);
   assign rd_quot = rd_prod[dcfcc_pkg::VOLT_PROD_WIDTH-1:dcfcc_pkg::VOLT_SHIFT];

   always_comb begin
      result = '0;
      case (s1_ff.command)
         dcfcc_pkg::CMD_BUILD_WRITE: begin
            result.frame_word = wr_frame;
         end
         default: begin
            result.crc_ok         = (rd_crc == s1_ff.reply_word[9:2]);
            result.match_ok       = (rd_dev == s1_ff.device_index) &&
                                    (rd_reg == s1_ff.write_data[7:2]);
            result.reply_device   = rd_dev;
            result.reply_register = rd_reg;
            result.reply_data     = s1_ff.reply_word[20:13] & dcfcc_pkg::BYTE_MASK;
            result.adc_code       = rd_code;
            result.voltage_mv     = 13'(rd_quot) + 13'(dcfcc_pkg::VOLT_OFFSET);
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff     <= dcfcc_pkg::CRC_POLY_RESET;
         tail_ff     <= dcfcc_pkg::TAIL_RESET;
         ctl_low_ff  <= dcfcc_pkg::CONTROL_LOW_RESET;
         basis_ff    <= dcfcc_pkg::crc_basis(dcfcc_pkg::CRC_POLY_RESET);
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         poly_ff     <= poly_in;
         tail_ff     <= tail_in;
         ctl_low_ff  <= ctl_low_in;
         basis_ff    <= basis_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   // ------------------------------------------------------------------
   // Response outputs
   // ------------------------------------------------------------------
   assign rsp_if.valid          = s2_valid_ff;
   assign rsp_if.frame_word     = s2_ff.frame_word;
   assign rsp_if.crc_ok         = s2_ff.crc_ok;
   assign rsp_if.match_ok       = s2_ff.match_ok;
   assign rsp_if.reply_device   = s2_ff.reply_device;
   assign rsp_if.reply_register = s2_ff.reply_register;
   assign rsp_if.reply_data     = s2_ff.reply_data;
   assign rsp_if.adc_code       = s2_ff.adc_code;
   assign rsp_if.voltage_mv     = s2_ff.voltage_mv;

endmodule

[rtl/dcfcc_checker.sv]
// ----------------------------------------------------------------------------
// dcfcc_checker - port-level assertions for the frame codec
// Watches the response channel; attached to the core by bind.
// ----------------------------------------------------------------------------
module dcfcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] frame_word,
   input logic        crc_ok,
   input logic        match_ok,
   input logic [11:0] adc_code,
   input logic [12:0] voltage_mv
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response stays up
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a nonzero frame only comes from a write build, so check fields are clear
   a_write_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_word != 32'd0 |-> !crc_ok && !match_ok && voltage_mv == 13'd0)
      else $error("write frame with check fields set");

   // converted voltage stays in range
   a_volt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && voltage_mv != 13'd0 |-> voltage_mv >= 13'd1000 && voltage_mv <= 13'd5000)
      else $error("voltage out of range");

   // full-scale code maps to full-scale voltage
   a_volt_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && voltage_mv != 13'd0 && adc_code == 12'hFFF |-> voltage_mv == 13'd5000)
      else $error("full-scale conversion wrong");

endmodule

bind daisy_chain_frame_crc_codec_core dcfcc_checker u_dcfcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .frame_word (rsp_if.frame_word),
   .crc_ok     (rsp_if.crc_ok),
   .match_ok   (rsp_if.match_ok),
   .adc_code   (rsp_if.adc_code),
   .voltage_mv (rsp_if.voltage_mv)
);
